>>> hw/rtl/lca_pkg.sv
package lca_pkg;

  localparam int NODE_BITS = 16;
  localparam int LEVELS    = 17;

  localparam int LvlW        = $clog2(LEVELS);
  localparam int AncAddrW    = LvlW + NODE_BITS;
  localparam int AncDepth    = LEVELS << NODE_BITS;
  localparam int DepDepth    = 1 << NODE_BITS;
  localparam int unsigned NodeMask = (1 << NODE_BITS) - 1;

  typedef logic [15:0]           node_t;
  typedef logic [NODE_BITS-1:0]  node_idx_t;
  typedef logic [LvlW-1:0]       lvl_t;
  typedef logic [AncAddrW-1:0]   anc_addr_t;

  localparam lvl_t LvlTop = lvl_t'(LEVELS - 1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_ANSWER  = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_RD1,
    ST_B_RD2,
    ST_B_WR,
    ST_Q_DEP,
    ST_Q_SWAP,
    ST_Q_LIFT,
    ST_Q_LIFT_B,
    ST_Q_LIFT_D,
    ST_Q_CHK,
    ST_Q_UP,
    ST_Q_UP_C,
    ST_Q_FIN,
    ST_Q_OUT
  } state_t;

  // table access request, one cycle
  typedef struct packed {
    logic      anc_we;
    anc_addr_t anc_waddr;
    node_t     anc_wdata;
    anc_addr_t anc_raddr_a;
    anc_addr_t anc_raddr_b;
    logic      dep_we;
    node_idx_t dep_waddr;
    node_t     dep_wdata;
    node_idx_t dep_raddr_a;
    node_idx_t dep_raddr_b;
  } tbl_req_t;

  typedef struct packed {
    logic lift;    // depth gap covers 2^level
    logic differ;  // ancestors at this level differ
  } step_res_t;

  function automatic anc_addr_t anc_addr(lvl_t lvl, node_t node);
    return {lvl, node_idx_t'(node)};
  endfunction

  function automatic logic id_ok(node_t id, node_t count);
    return (id != 16'd0) && (id <= count) && (32'(id) <= NodeMask);
  endfunction

  function automatic node_t build_limit(node_t count);
    return (32'(count) > NodeMask) ? node_t'(NodeMask) : count;
  endfunction

endpackage

>>> hw/rtl/lca_tables.sv
module lca_tables (
  input  logic             clk,
  input  lca_pkg::tbl_req_t req,
  output lca_pkg::node_t   anc_a_q,
  output lca_pkg::node_t   anc_b_q,
  output lca_pkg::node_t   dep_a_q,
  output lca_pkg::node_t   dep_b_q
);
  import lca_pkg::*;

  // ancestor table: level in upper address bits, node in lower
  node_t anc_mem [AncDepth];
  node_t dep_mem [DepDepth];

  always_ff @(posedge clk) begin
    if (req.anc_we) begin
      anc_mem[req.anc_waddr] <= req.anc_wdata;
    end
    anc_a_q <= anc_mem[req.anc_raddr_a];
    anc_b_q <= anc_mem[req.anc_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (req.dep_we) begin
      dep_mem[req.dep_waddr] <= req.dep_wdata;
    end
    dep_a_q <= dep_mem[req.dep_raddr_a];
    dep_b_q <= dep_mem[req.dep_raddr_b];
  end

endmodule

>>> hw/rtl/lca_step_unit.sv
module lca_step_unit (
  input  lca_pkg::node_t    depth_a,
  input  lca_pkg::node_t    depth_b,
  input  lca_pkg::lvl_t     level,
  input  lca_pkg::node_t    anc_a,
  input  lca_pkg::node_t    anc_b,
  output lca_pkg::step_res_t res
);
  import lca_pkg::*;

  logic [16:0] gap;
  logic [31:0] span;

  always_comb begin
    gap        = {1'b0, depth_b} - {1'b0, depth_a};
    span       = 32'd1 << level;
    // negative gap never lifts
    res.lift   = !gap[16] && (32'(gap[15:0]) >= span);
    res.differ = (anc_a != anc_b);
  end

endmodule

>>> hw/rtl/lca_binary_lifting_unit.sv
// Lowest-common-ancestor engine using binary lifting. Pulse start while busy
// is low to transfer one command: load (write a node's parent and depth),
// build (fill ancestor levels 1..LEVELS-1 for nodes 1..node_count) or query
// (lowest common ancestor of two nodes). A load with a valid id stays idle and
// gives no result; unused operation code 3 is dropped. Every other command
// returns exactly one result, shown for one cycle with out_valid high, in the
// cycle after its last step. The receiver cannot stall: sample every out_valid
// cycle. A query reads both depths, lifts the deeper node by each power of
// two the depth gap covers and, if the nodes still differ, climbs both while
// their ancestors differ. A build reads anc[l-1][j], then anc[l-1] of that
// node, and writes anc[l][j]. Both are paced by the ancestor table, which
// serves one read pair per cycle, and by the dependent read-then-read chain
// of each fill. Invalid ids answer in the cycle after the command. The tables
// are not cleared at reset: load every node before build or query. The user
// must write node_count through cfg_wr_en/cfg_wr_data only while idle; the
// unit does not enforce this.
module lca_binary_lifting_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_operation,
  input  lca_pkg::node_t        in_node_a,
  input  lca_pkg::node_t        in_node_b,
  input  lca_pkg::node_t        in_node_level,
  output logic                  out_valid,
  output logic [1:0]            out_result_kind,
  output lca_pkg::node_t        out_ancestor_node,
  input  logic                  cfg_wr_en,
  input  lca_pkg::node_t        cfg_wr_data
);
  import lca_pkg::*;

  state_t    state_r, state_nxt;
  node_t     a_r, a_nxt;
  node_t     b_r, b_nxt;
  node_t     da_r, da_nxt;
  node_t     db_r, db_nxt;
  lvl_t      lvl_r, lvl_nxt;
  node_t     j_r, j_nxt;
  node_t     lim_r, lim_nxt;
  node_t     node_count_r;
  logic      out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  node_t     out_node_r, out_node_nxt;

  tbl_req_t  req;
  node_t     anc_a_q, anc_b_q, dep_a_q, dep_b_q;
  step_res_t step;

  lca_tables u_tables (
    .clk     (clk),
    .req     (req),
    .anc_a_q (anc_a_q),
    .anc_b_q (anc_b_q),
    .dep_a_q (dep_a_q),
    .dep_b_q (dep_b_q)
  );

  // shared compare unit: depth gap test in the lift pass, ancestor
  // mismatch in the climb pass
  lca_step_unit u_step (
    .depth_a (da_r),
    .depth_b (db_r),
    .level   (lvl_r),
    .anc_a   (anc_a_q),
    .anc_b   (anc_b_q),
    .res     (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      node_count_r <= 16'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    lvl_r      <= lvl_nxt;
    j_r        <= j_nxt;
    lim_r      <= lim_nxt;
    out_kind_r <= out_kind_nxt;
    out_node_r <= out_node_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    lvl_nxt       = lvl_r;
    j_nxt         = j_r;
    lim_nxt       = lim_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_node_nxt  = out_node_r;
    req           = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_operation)
            OP_LOAD: begin
              if (id_ok(in_node_a, node_count_r)) begin
                req.anc_we    = 1'b1;
                req.anc_waddr = anc_addr('0, in_node_a);
                req.anc_wdata = in_node_b;
                req.dep_we    = 1'b1;
                req.dep_waddr = node_idx_t'(in_node_a);
                req.dep_wdata = in_node_level;
              end else begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_INVALID;
                out_node_nxt  = '0;
              end
            end
            OP_BUILD: begin
              lim_nxt = build_limit(node_count_r);
              lvl_nxt = lvl_t'(1);
              j_nxt   = 16'd1;
              if (build_limit(node_count_r) == 16'd0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_DONE;
                out_node_nxt  = '0;
              end else begin
                state_nxt = ST_B_RD1;
              end
            end
            OP_QUERY: begin
              if (id_ok(in_node_a, node_count_r) && id_ok(in_node_b, node_count_r)) begin
                a_nxt     = in_node_a;
                b_nxt     = in_node_b;
                state_nxt = ST_Q_DEP;
              end else begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_INVALID;
                out_node_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end

      // build: anc[l][j] = anc[l-1][anc[l-1][j]]
      ST_B_RD1: begin
        req.anc_raddr_a = anc_addr(lvl_r - lvl_t'(1), j_r);
        state_nxt       = ST_B_RD2;
      end
      ST_B_RD2: begin
        req.anc_raddr_a = anc_addr(lvl_r - lvl_t'(1), anc_a_q);
        state_nxt       = ST_B_WR;
      end
      ST_B_WR: begin
        req.anc_we    = 1'b1;
        req.anc_waddr = anc_addr(lvl_r, j_r);
        req.anc_wdata = anc_a_q;
        state_nxt     = ST_B_RD1;
        if (j_r == lim_r) begin
          j_nxt = 16'd1;
          if (lvl_r == LvlTop) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_DONE;
            out_node_nxt  = '0;
            state_nxt     = ST_IDLE;
          end else begin
            lvl_nxt = lvl_r + lvl_t'(1);
          end
        end else begin
          j_nxt = j_r + 16'd1;
        end
      end

      // query: fetch both depths, keep the shallower node in a
      ST_Q_DEP: begin
        req.dep_raddr_a = node_idx_t'(a_r);
        req.dep_raddr_b = node_idx_t'(b_r);
        state_nxt       = ST_Q_SWAP;
      end
      ST_Q_SWAP: begin
        lvl_nxt   = LvlTop;
        state_nxt = ST_Q_LIFT;
        if (dep_a_q > dep_b_q) begin
          a_nxt  = b_r;
          b_nxt  = a_r;
          da_nxt = dep_b_q;
          db_nxt = dep_a_q;
        end else begin
          da_nxt = dep_a_q;
          db_nxt = dep_b_q;
        end
      end
      ST_Q_LIFT: begin
        if (step.lift) begin
          req.anc_raddr_b = anc_addr(lvl_r, b_r);
          state_nxt       = ST_Q_LIFT_B;
        end else if (lvl_r == '0) begin
          state_nxt = ST_Q_CHK;
        end else begin
          lvl_nxt = lvl_r - lvl_t'(1);
        end
      end
      ST_Q_LIFT_B: begin
        b_nxt           = anc_b_q;
        req.dep_raddr_b = node_idx_t'(anc_b_q);
        state_nxt       = ST_Q_LIFT_D;
      end
      ST_Q_LIFT_D: begin
        db_nxt = dep_b_q;
        if (lvl_r == '0) begin
          state_nxt = ST_Q_CHK;
        end else begin
          lvl_nxt   = lvl_r - lvl_t'(1);
          state_nxt = ST_Q_LIFT;
        end
      end
      ST_Q_CHK: begin
        if (a_r == b_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ANSWER;
          out_node_nxt  = a_r;
          state_nxt     = ST_IDLE;
        end else begin
          lvl_nxt   = LvlTop;
          state_nxt = ST_Q_UP;
        end
      end

      // climb both nodes while their ancestors differ
      ST_Q_UP: begin
        req.anc_raddr_a = anc_addr(lvl_r, a_r);
        req.anc_raddr_b = anc_addr(lvl_r, b_r);
        state_nxt       = ST_Q_UP_C;
      end
      ST_Q_UP_C: begin
        if (step.differ) begin
          a_nxt = anc_a_q;
          b_nxt = anc_b_q;
        end
        if (lvl_r == '0) begin
          state_nxt = ST_Q_FIN;
        end else begin
          lvl_nxt   = lvl_r - lvl_t'(1);
          state_nxt = ST_Q_UP;
        end
      end
      ST_Q_FIN: begin
        req.anc_raddr_a = anc_addr('0, a_r);
        state_nxt       = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ANSWER;
        out_node_nxt  = anc_a_q;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_ancestor_node = out_node_r;

endmodule

>>> hw/rtl/lca_checker.sv
module lca_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic [1:0]     in_operation,
  input lca_pkg::node_t in_node_a,
  input logic           out_valid,
  input logic [1:0]     out_result_kind,
  input lca_pkg::node_t out_ancestor_node
);
  import lca_pkg::*;

  logic xfer;
  assign xfer = start && !busy;

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind == KIND_DONE || out_result_kind == KIND_ANSWER ||
                   out_result_kind == KIND_INVALID))
    else $error("illegal result kind");

  a_zero_node: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind != KIND_ANSWER) |-> (out_ancestor_node == '0))
    else $error("non-answer result carries a node");

  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && in_node_a == '0 && (in_operation == OP_LOAD || in_operation == OP_QUERY))
    |=> (out_valid && out_result_kind == KIND_INVALID && !busy))
    else $error("node id zero not rejected");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && (in_operation == OP_LOAD || in_operation == OP_UNUSED)) |=> !busy)
    else $error("load or unused op left the unit busy");

  a_no_spont: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> (!busy && !out_valid))
    else $error("activity without a command");

endmodule

bind lca_binary_lifting_unit lca_checker u_lca_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_operation      (in_operation),
  .in_node_a         (in_node_a),
  .out_valid         (out_valid),
  .out_result_kind   (out_result_kind),
  .out_ancestor_node (out_ancestor_node)
);
